>>> src/mksd_pkg.sv
package mksd_pkg;

  localparam int unsigned ROWS = 4;
  localparam int unsigned COLS = 4;
  localparam int unsigned KEYS = ROWS * COLS;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam int unsigned COL_SENSE_W = 4;
  localparam int unsigned ROW_DRIVE_W = 4;
  localparam int unsigned KEY_CODE_W = 5;

  localparam int unsigned THR_W = 8;
  localparam logic [THR_W-1:0] THR_RESET = 8'd8;

  // APB register map: one 32-bit register at byte address 0
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = '0;

  typedef logic [COLS-1:0] row_bits_t;

endpackage

>>> src/mksd_if.sv
interface mksd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [mksd_pkg::COL_SENSE_W-1:0]     column_sense;

  modport source (output valid, output column_sense, input ready);
  modport sink (input valid, input column_sense, output ready);
endinterface

interface mksd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [mksd_pkg::ROW_DRIVE_W-1:0]     row_drive;
  logic [mksd_pkg::KEY_CODE_W-1:0]      key_code;

  modport source (output valid, output row_drive, output key_code, input ready);
  modport sink (input valid, input row_drive, input key_code, output ready);
endinterface

>>> src/mksd_cell.sv
// One key lane: integrating debounce counter plus stable flag.
module mksd_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       upd_i,
  input  logic                       pressed_i,
  input  logic [mksd_pkg::THR_W-1:0] thresh_i,
  output logic                       stable_o
);

  logic [mksd_pkg::THR_W-1:0] cnt_q, cnt_d;
  logic                       stable_q, stable_d;

  always_comb begin
    cnt_d    = cnt_q;
    stable_d = stable_q;
    if (upd_i) begin
      if (pressed_i) begin
        if (cnt_q < thresh_i) begin
          cnt_d = cnt_q + 1'b1;
        end else begin
          stable_d = 1'b1;
        end
      end else begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
        end else begin
          stable_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      stable_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      stable_q <= stable_d;
    end
  end

  // next flag, so the result of this transfer already sees the update
  assign stable_o = stable_d;

endmodule

>>> src/mksd_merge.sv
// Merge of the lanes: lowest-numbered stable key wins, code is index + 1.
module mksd_merge (
  input  logic [mksd_pkg::KEYS-1:0]       stable_i,
  output logic [mksd_pkg::KEY_CODE_W-1:0] key_code_o
);

  always_comb begin
    key_code_o = '0;
    for (int k = mksd_pkg::KEYS - 1; k >= 0; k--) begin
      if (stable_i[k]) begin
        key_code_o = mksd_pkg::KEY_CODE_W'(k + 1);
      end
    end
  end

endmodule

>>> src/matrix_keypad_scan_debounce_unit.sv
// Keypad scanner with per-key integrating debounce.
// Result: valid in the cycle after the scan tick transfer (output register).
// Throughput: a tick per cycle unless stalled; all key lanes update on the last row.
// Reset: row index, raw rows, counters and stable flags clear; threshold resets to 8.
module matrix_keypad_scan_debounce_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mksd_in_if.sink                         sense_i,
  mksd_out_if.source                      result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mksd_pkg::PADDR_W-1:0]    paddr,
  input  logic [mksd_pkg::PDATA_W-1:0]    pwdata,
  output logic [mksd_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  // ---------------- configuration ----------------
  logic [mksd_pkg::THR_W-1:0]     thresh_q;
  logic [mksd_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[mksd_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= mksd_pkg::THR_RESET;
    end else if (cfg_wr && (reg_idx == mksd_pkg::REG_THRESHOLD)) begin
      thresh_q <= pwdata[mksd_pkg::THR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == mksd_pkg::REG_THRESHOLD) begin
      prdata = mksd_pkg::PDATA_W'(thresh_q);
    end
  end

  // ---------------- scan ----------------
  logic                          in_xfer;
  logic                          out_valid_q;
  logic [mksd_pkg::ROW_W-1:0]    row_q, row_d;
  mksd_pkg::row_bits_t           raw_q   [mksd_pkg::ROWS];
  mksd_pkg::row_bits_t           raw_now [mksd_pkg::ROWS];
  logic                          last_row;
  logic                          upd;
  logic [mksd_pkg::KEYS-1:0]     stable;
  logic [mksd_pkg::KEY_CODE_W-1:0]  key_code;
  logic [mksd_pkg::ROW_DRIVE_W-1:0] drive;
  logic [mksd_pkg::ROW_DRIVE_W-1:0] drive_q;
  logic [mksd_pkg::KEY_CODE_W-1:0]  key_code_q;

  assign sense_i.ready = !out_valid_q || result_o.ready;
  assign in_xfer       = sense_i.valid && sense_i.ready;
  assign last_row      = (row_q == mksd_pkg::ROW_W'(mksd_pkg::ROWS - 1));
  assign upd           = in_xfer && last_row;
  assign row_d         = last_row ? '0 : row_q + 1'b1;

  // current row sees this tick's column bits
  always_comb begin
    for (int r = 0; r < mksd_pkg::ROWS; r++) begin
      raw_now[r] = raw_q[r];
      if (row_q == mksd_pkg::ROW_W'(r)) begin
        raw_now[r] = sense_i.column_sense[mksd_pkg::COLS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      for (int r = 0; r < mksd_pkg::ROWS; r++) begin
        raw_q[r] <= '0;
      end
    end else if (in_xfer) begin
      row_q <= row_d;
      for (int r = 0; r < mksd_pkg::ROWS; r++) begin
        raw_q[r] <= raw_now[r];
      end
    end
  end

  for (genvar r = 0; r < mksd_pkg::ROWS; r++) begin : g_row
    for (genvar c = 0; c < mksd_pkg::COLS; c++) begin : g_col
      mksd_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .upd_i     (upd),
        .pressed_i (raw_now[r][c]),
        .thresh_i  (thresh_q),
        .stable_o  (stable[r*mksd_pkg::COLS + c])
      );
    end
  end

  mksd_merge u_merge (
    .stable_i   (stable),
    .key_code_o (key_code)
  );

  always_comb begin
    for (int i = 0; i < mksd_pkg::ROW_DRIVE_W; i++) begin
      drive[i] = (i < mksd_pkg::ROWS) && (row_d == mksd_pkg::ROW_W'(i));
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sense_i.ready) begin
      out_valid_q <= sense_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      drive_q    <= drive;
      key_code_q <= key_code;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.row_drive = drive_q;
  assign result_o.key_code  = key_code_q;

  // ---------------- assertions ----------------
  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && last_row) |=> (row_q == '0))
    else $error("row index did not wrap after last row");

  a_row_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer |=> $stable(row_q))
    else $error("row index moved without a transfer");

  a_drive_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot(drive_q))
    else $error("row drive not one-hot");

  a_drive_matches_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (drive_q == (mksd_pkg::ROW_DRIVE_W'(1) << row_q)))
    else $error("row drive disagrees with row index");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (key_code_q <= mksd_pkg::KEY_CODE_W'(mksd_pkg::KEYS)))
    else $error("key code out of range");

endmodule
